FILE: sv/gmdr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gmdr_pkg
// shared sizes, cell kinds, walk status codes and register indexes for the
// grid maze reachability block
// ----------------------------------------------------------------------------
package gmdr_pkg;

  // store geometry
  localparam int MAX_ROWS    = 64;
  localparam int MAX_COLUMNS = 64;
  localparam int STACK_DEPTH = 16384;

  localparam int ROW_W  = $clog2(MAX_ROWS);
  localparam int COL_W  = $clog2(MAX_COLUMNS);
  localparam int GA_W   = $clog2(MAX_ROWS * MAX_COLUMNS);
  localparam int POS_W  = ROW_W + COL_W;
  localparam int STK_AW = $clog2(STACK_DEPTH);
  localparam int SP_W   = $clog2(STACK_DEPTH + 1);

  // transfer field widths
  localparam int IDX_W     = 6;
  localparam int KIND_W    = 2;
  localparam int STATUS_W  = 2;
  localparam int CFG_W     = 7;
  localparam int CFG_IDX_W = 2;

  // width wide enough for any row, column or count compare
  localparam int CMP_W = ((ROW_W > COL_W) ? ROW_W : COL_W) + IDX_W + CFG_W + 1;

  // operations
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_START = 1'b1;

  // cell kinds
  localparam logic [KIND_W-1:0] KIND_WALL    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_OPEN    = 2'd1;
  localparam logic [KIND_W-1:0] KIND_EXIT    = 2'd2;
  localparam logic [KIND_W-1:0] KIND_VISITED = 2'd3;

  // walk status
  localparam logic [STATUS_W-1:0] WALK_NO_EXIT  = 2'd0;
  localparam logic [STATUS_W-1:0] WALK_FOUND    = 2'd1;
  localparam logic [STATUS_W-1:0] WALK_OVERFLOW = 2'd2;
  localparam logic [STATUS_W-1:0] WALK_OUTSIDE  = 2'd3;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COLUMN_COUNT = 2'd1;

  localparam logic [CFG_W-1:0] COUNT_RESET = 7'd64;

endpackage

FILE: sv/gmdr_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gmdr_in_if
// input channel: cell writes and walk starts
// ----------------------------------------------------------------------------
interface gmdr_in_if;
  logic                         valid;
  logic                         ready;
  logic                         op;
  logic [gmdr_pkg::IDX_W-1:0]   row_index;
  logic [gmdr_pkg::IDX_W-1:0]   column_index;
  logic [gmdr_pkg::KIND_W-1:0]  cell_kind;

  modport source (output valid, output op, output row_index, output column_index,
                  output cell_kind, input ready);
  modport sink (input valid, input op, input row_index, input column_index,
                input cell_kind, output ready);
endinterface

FILE: sv/gmdr_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gmdr_out_if
// result channel: walk status and final position
// ----------------------------------------------------------------------------
interface gmdr_out_if;
  logic                           valid;
  logic                           ready;
  logic [gmdr_pkg::STATUS_W-1:0]  walk_status;
  logic [gmdr_pkg::IDX_W-1:0]     final_row;
  logic [gmdr_pkg::IDX_W-1:0]     final_column;

  modport source (output valid, output walk_status, output final_row,
                  output final_column, input ready);
  modport sink (input valid, input walk_status, input final_row,
                input final_column, output ready);
endinterface

FILE: sv/gmdr_cfg_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gmdr_cfg_if
// configuration write channel: register index and data
// ----------------------------------------------------------------------------
interface gmdr_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [gmdr_pkg::CFG_IDX_W-1:0]  index;
  logic [gmdr_pkg::CFG_W-1:0]      data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

FILE: sv/grid_maze_dfs_reachability_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grid_maze_dfs_reachability_top
// grid maze loader and stack based depth-first reachability walk
// ----------------------------------------------------------------------------
// in_chan carries items: op write stores one cell kind into the grid memory,
// op start runs a walk from the given position. out_chan returns one result
// per start: walk status and final position. cfg_chan writes row_count and
// column_count, always ready; it is to be used only while the block is idle,
// which the block itself does not enforce. Cell writes are taken one per
// cycle while the block is idle and give no result. A start is taken only
// in idle; in_chan then stays not ready until the result is loaded into the
// output register. A start outside the grid goes straight to the done step.
// Inside, each explored cell takes a read and an evaluate step for itself and
// per in-bound neighbour, a read step per out-of-bound neighbour, a mark and
// a pop step; the grid memory has a registered read. Stack pushes and pops
// go to a second memory. When out_chan stalls, the finished result waits and
// in_chan stays blocked; cell writes still flow while an earlier result waits.
// Reset clears control state and sets both counts to 64; grid and stack
// memories are not cleared, a grid cell must be written before a walk reads it.
// ----------------------------------------------------------------------------
module grid_maze_dfs_reachability_top (
  input  logic              clk,
  input  logic              rst_n,
  gmdr_in_if.sink           in_chan,
  gmdr_out_if.source        out_chan,
  gmdr_cfg_if.sink          cfg_chan
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD,
    ST_EVAL,
    ST_MARK,
    ST_POP,
    ST_DONE
  } state_t;

  typedef enum logic [2:0] {
    DIR_CELL,
    DIR_NORTH,
    DIR_EAST,
    DIR_SOUTH,
    DIR_WEST
  } dir_t;

  state_t                              state_r;
  dir_t                                dir_r;
  logic [gmdr_pkg::SP_W-1:0]           sp_r;
  logic [gmdr_pkg::ROW_W-1:0]          cur_row_r;
  logic [gmdr_pkg::COL_W-1:0]          cur_col_r;
  logic [gmdr_pkg::CFG_W-1:0]          row_count_r;
  logic [gmdr_pkg::CFG_W-1:0]          column_count_r;
  logic [gmdr_pkg::STATUS_W-1:0]       res_status_r;
  logic [gmdr_pkg::IDX_W-1:0]          res_row_r;
  logic [gmdr_pkg::IDX_W-1:0]          res_col_r;
  logic                                out_valid_r;
  logic [gmdr_pkg::STATUS_W-1:0]       out_status_r;
  logic [gmdr_pkg::IDX_W-1:0]          out_row_r;
  logic [gmdr_pkg::IDX_W-1:0]          out_col_r;

  // memories
  logic [gmdr_pkg::KIND_W-1:0]         grid_mem [gmdr_pkg::MAX_ROWS*gmdr_pkg::MAX_COLUMNS];
  logic [gmdr_pkg::POS_W-1:0]          stack_mem [gmdr_pkg::STACK_DEPTH];
  logic [gmdr_pkg::KIND_W-1:0]         grid_q;
  logic [gmdr_pkg::POS_W-1:0]          stack_q;

  logic                                grid_we;
  logic [gmdr_pkg::GA_W-1:0]           grid_wa;
  logic [gmdr_pkg::KIND_W-1:0]         grid_wd;
  logic                                grid_re;
  logic                                stk_we;
  logic                                stk_re;
  logic [gmdr_pkg::STK_AW-1:0]         stk_ra;

  logic                                in_xfer;
  logic                                out_xfer;
  logic                                cfg_xfer;
  logic                                in_store;
  logic                                start_inside;
  logic [gmdr_pkg::GA_W-1:0]           in_addr;
  logic [gmdr_pkg::GA_W-1:0]           cur_addr;
  logic [gmdr_pkg::GA_W-1:0]           nb_addr;
  logic [gmdr_pkg::ROW_W:0]            nb_row;
  logic [gmdr_pkg::COL_W:0]            nb_col;
  logic                                nb_ok;
  logic                                passable;
  logic                                stack_full;
  logic [gmdr_pkg::SP_W-1:0]           sp_m1;

  function automatic logic in_rows(input logic [gmdr_pkg::CMP_W-1:0] x,
                                   input logic [gmdr_pkg::CFG_W-1:0] cnt);
    in_rows = (x < gmdr_pkg::CMP_W'(cnt)) &&
              (x < gmdr_pkg::CMP_W'(gmdr_pkg::MAX_ROWS));
  endfunction

  function automatic logic in_cols(input logic [gmdr_pkg::CMP_W-1:0] x,
                                   input logic [gmdr_pkg::CFG_W-1:0] cnt);
    in_cols = (x < gmdr_pkg::CMP_W'(cnt)) &&
              (x < gmdr_pkg::CMP_W'(gmdr_pkg::MAX_COLUMNS));
  endfunction

  function automatic dir_t next_dir(input dir_t d);
    case (d)
      DIR_CELL:  next_dir = DIR_NORTH;
      DIR_NORTH: next_dir = DIR_EAST;
      DIR_EAST:  next_dir = DIR_SOUTH;
      DIR_SOUTH: next_dir = DIR_WEST;
      default:   next_dir = DIR_WEST;
    endcase
  endfunction

  assign in_xfer  = in_chan.valid && in_chan.ready;
  assign out_xfer = out_chan.valid && out_chan.ready;
  assign cfg_xfer = cfg_chan.valid && cfg_chan.ready;

  assign in_chan.ready        = (state_r == ST_IDLE);
  assign cfg_chan.ready       = 1'b1;
  assign out_chan.valid       = out_valid_r;
  assign out_chan.walk_status = out_status_r;
  assign out_chan.final_row   = out_row_r;
  assign out_chan.final_column = out_col_r;

  assign in_store = (gmdr_pkg::CMP_W'(in_chan.row_index) <
                     gmdr_pkg::CMP_W'(gmdr_pkg::MAX_ROWS)) &&
                    (gmdr_pkg::CMP_W'(in_chan.column_index) <
                     gmdr_pkg::CMP_W'(gmdr_pkg::MAX_COLUMNS));
  assign start_inside = in_rows(gmdr_pkg::CMP_W'(in_chan.row_index), row_count_r) &&
                        in_cols(gmdr_pkg::CMP_W'(in_chan.column_index), column_count_r);

  assign in_addr  = gmdr_pkg::GA_W'(32'(in_chan.row_index) * gmdr_pkg::MAX_COLUMNS +
                                    32'(in_chan.column_index));
  assign cur_addr = gmdr_pkg::GA_W'(32'(cur_row_r) * gmdr_pkg::MAX_COLUMNS +
                                    32'(cur_col_r));
  assign nb_addr  = gmdr_pkg::GA_W'(32'(nb_row[gmdr_pkg::ROW_W-1:0]) * gmdr_pkg::MAX_COLUMNS +
                                    32'(nb_col[gmdr_pkg::COL_W-1:0]));

  // neighbour position for the current step
  always_comb begin
    nb_row = {1'b0, cur_row_r};
    nb_col = {1'b0, cur_col_r};
    nb_ok  = 1'b1;
    case (dir_r)
      DIR_CELL: begin
        nb_ok = 1'b1;
      end
      DIR_NORTH: begin
        nb_row = {1'b0, cur_row_r} - 1'b1;
        nb_ok  = (cur_row_r != '0);
      end
      DIR_EAST: begin
        nb_col = {1'b0, cur_col_r} + 1'b1;
      end
      DIR_SOUTH: begin
        nb_row = {1'b0, cur_row_r} + 1'b1;
      end
      default: begin
        nb_col = {1'b0, cur_col_r} - 1'b1;
        nb_ok  = (cur_col_r != '0);
      end
    endcase
    if (dir_r != DIR_CELL) begin
      nb_ok = nb_ok && in_rows(gmdr_pkg::CMP_W'(nb_row), row_count_r) &&
              in_cols(gmdr_pkg::CMP_W'(nb_col), column_count_r);
    end
  end

  assign passable   = (grid_q == gmdr_pkg::KIND_OPEN) || (grid_q == gmdr_pkg::KIND_EXIT);
  assign stack_full = (sp_r == gmdr_pkg::SP_W'(gmdr_pkg::STACK_DEPTH));
  assign sp_m1      = sp_r - 1'b1;

  // memory control
  always_comb begin
    grid_we = 1'b0;
    grid_wa = in_addr;
    grid_wd = in_chan.cell_kind;
    if (state_r == ST_MARK) begin
      grid_we = 1'b1;
      grid_wa = cur_addr;
      grid_wd = gmdr_pkg::KIND_VISITED;
    end else if (in_xfer && (in_chan.op == gmdr_pkg::OP_WRITE) && in_store) begin
      grid_we = 1'b1;
    end
  end

  assign grid_re = (state_r == ST_RD) && nb_ok;
  assign stk_we  = (state_r == ST_EVAL) && (dir_r != DIR_CELL) && passable && !stack_full;
  assign stk_re  = (state_r == ST_MARK) && (sp_r != '0);
  assign stk_ra  = sp_m1[gmdr_pkg::STK_AW-1:0];

  always_ff @(posedge clk) begin
    if (grid_we) begin
      grid_mem[grid_wa] <= grid_wd;
    end
    if (grid_re) begin
      grid_q <= grid_mem[nb_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (stk_we) begin
      stack_mem[sp_r[gmdr_pkg::STK_AW-1:0]] <= {nb_row[gmdr_pkg::ROW_W-1:0],
                                                nb_col[gmdr_pkg::COL_W-1:0]};
    end
    if (stk_re) begin
      stack_q <= stack_mem[stk_ra];
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_count_r    <= gmdr_pkg::COUNT_RESET;
      column_count_r <= gmdr_pkg::COUNT_RESET;
    end else if (cfg_xfer) begin
      case (cfg_chan.index)
        gmdr_pkg::REG_ROW_COUNT:    row_count_r    <= cfg_chan.data;
        gmdr_pkg::REG_COLUMN_COUNT: column_count_r <= cfg_chan.data;
        default: ;
      endcase
    end
  end

  // walk sequencer and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      dir_r       <= DIR_CELL;
      sp_r        <= '0;
      cur_row_r   <= '0;
      cur_col_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_xfer && (state_r != ST_DONE)) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_xfer && (in_chan.op == gmdr_pkg::OP_START)) begin
            sp_r  <= '0;
            dir_r <= DIR_CELL;
            if (start_inside) begin
              cur_row_r <= gmdr_pkg::ROW_W'(in_chan.row_index);
              cur_col_r <= gmdr_pkg::COL_W'(in_chan.column_index);
              state_r   <= ST_RD;
            end else begin
              res_status_r <= gmdr_pkg::WALK_OUTSIDE;
              res_row_r    <= in_chan.row_index;
              res_col_r    <= in_chan.column_index;
              state_r      <= ST_DONE;
            end
          end
        end
        ST_RD: begin
          if (nb_ok) begin
            state_r <= ST_EVAL;
          end else if (dir_r == DIR_WEST) begin
            state_r <= ST_MARK;
          end else begin
            dir_r <= next_dir(dir_r);
          end
        end
        ST_EVAL: begin
          if (dir_r == DIR_CELL) begin
            if (grid_q == gmdr_pkg::KIND_EXIT) begin
              res_status_r <= gmdr_pkg::WALK_FOUND;
              res_row_r    <= gmdr_pkg::IDX_W'(cur_row_r);
              res_col_r    <= gmdr_pkg::IDX_W'(cur_col_r);
              state_r      <= ST_DONE;
            end else begin
              dir_r   <= DIR_NORTH;
              state_r <= ST_RD;
            end
          end else if (passable && stack_full) begin
            res_status_r <= gmdr_pkg::WALK_OVERFLOW;
            res_row_r    <= gmdr_pkg::IDX_W'(cur_row_r);
            res_col_r    <= gmdr_pkg::IDX_W'(cur_col_r);
            state_r      <= ST_DONE;
          end else begin
            if (passable) begin
              sp_r <= sp_r + 1'b1;
            end
            if (dir_r == DIR_WEST) begin
              state_r <= ST_MARK;
            end else begin
              dir_r   <= next_dir(dir_r);
              state_r <= ST_RD;
            end
          end
        end
        ST_MARK: begin
          if (sp_r == '0) begin
            res_status_r <= gmdr_pkg::WALK_NO_EXIT;
            res_row_r    <= gmdr_pkg::IDX_W'(cur_row_r);
            res_col_r    <= gmdr_pkg::IDX_W'(cur_col_r);
            state_r      <= ST_DONE;
          end else begin
            sp_r    <= sp_m1;
            state_r <= ST_POP;
          end
        end
        ST_POP: begin
          cur_row_r <= stack_q[gmdr_pkg::POS_W-1:gmdr_pkg::COL_W];
          cur_col_r <= stack_q[gmdr_pkg::COL_W-1:0];
          dir_r     <= DIR_CELL;
          state_r   <= ST_RD;
        end
        ST_DONE: begin
          if (!out_valid_r || out_chan.ready) begin
            out_valid_r  <= 1'b1;
            out_status_r <= res_status_r;
            out_row_r    <= res_row_r;
            out_col_r    <= res_col_r;
            state_r      <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  // checks
  a_sp_bound: assert property (@(posedge clk) disable iff (!rst_n)
    sp_r <= gmdr_pkg::SP_W'(gmdr_pkg::STACK_DEPTH))
    else $error("stack pointer beyond stack depth");

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    stk_we |-> !stack_full)
    else $error("push onto a full stack");

  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_DONE))
    else $error("result raised outside the done step");

  a_walk_write_mark: assert property (@(posedge clk) disable iff (!rst_n)
    (grid_we && (state_r != ST_IDLE)) |->
      (state_r == ST_MARK && grid_wd == gmdr_pkg::KIND_VISITED))
    else $error("grid write during walk other than visited mark");

  a_pop_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_POP) |=> (state_r == ST_RD && dir_r == DIR_CELL))
    else $error("pop not followed by cell read");

endmodule

FILE: sim/grid_maze_dfs_reachability_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grid_maze_dfs_reachability_top_tb
// self-checking regression for the grid maze reachability block
// ----------------------------------------------------------------------------
// A short table of directed items is walked first: 1x1 and 2x2 mazes, an exit,
// a wall and a visited start cell, starts outside the grid and the extreme
// count settings. Random phases follow, each with its own row and column
// counts. Every phase reloads the maze area with random cells before it
// starts walks, with stray cell writes and starts outside the grid mixed in.
// A closing phase runs walks on a narrow grid of all 64 rows, set through a
// row count above the store size. Each start is predicted by a depth-first
// walk over a local copy of the grid (a typed directed start by a fixed
// result), and each result is compared field by field with the oldest
// prediction. Both sides pause at random, and the result side holds off for
// long stretches so that the input stalls behind a waiting result.
// ----------------------------------------------------------------------------
module grid_maze_dfs_reachability_top_tb;

  localparam int CYCLE_LIMIT = 4000000;
  localparam int ITEM_TARGET = 1000;
  localparam int CLOSING_RESERVE = 300;
  localparam int CLOSING_COLS = 4;
  localparam int SETTLE_CYCLES = 40;
  localparam int LONG_HOLD = 500;

  typedef struct packed {
    logic                         op;
    logic [gmdr_pkg::IDX_W-1:0]   row;
    logic [gmdr_pkg::IDX_W-1:0]   col;
    logic [gmdr_pkg::KIND_W-1:0]  kind;
  } maze_item_t;

  typedef struct packed {
    logic [gmdr_pkg::STATUS_W-1:0]  status;
    logic [gmdr_pkg::IDX_W-1:0]     row;
    logic [gmdr_pkg::IDX_W-1:0]     col;
  } walk_result_t;

  typedef struct {
    bit                              is_cfg;
    logic [gmdr_pkg::CFG_IDX_W-1:0]  reg_idx;
    logic [gmdr_pkg::CFG_W-1:0]      reg_val;
    maze_item_t                      item;
    bit                              typed;
    walk_result_t                    want;
  } directed_row_t;

  logic clk = 1'b0;
  logic rst_n;

  gmdr_in_if  in_if ();
  gmdr_out_if out_if ();
  gmdr_cfg_if cfg_if ();

  grid_maze_dfs_reachability_top i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if),
    .cfg_chan (cfg_if)
  );

  always #6 clk = ~clk;

  // local copy of the block state
  logic [gmdr_pkg::KIND_W-1:0] maze_cells [gmdr_pkg::MAX_ROWS*gmdr_pkg::MAX_COLUMNS];
  int                          trail [gmdr_pkg::STACK_DEPTH];
  int                          trail_len = 0;
  logic [gmdr_pkg::CFG_W-1:0]  row_count = gmdr_pkg::COUNT_RESET;
  logic [gmdr_pkg::CFG_W-1:0]  col_count = gmdr_pkg::COUNT_RESET;

  walk_result_t  expected_walks [$];
  directed_row_t directed_rows [$];
  int            errors = 0;
  int            items_sent = 0;
  int            cycle_count = 0;
  bit            tx_idle = 1'b1;
  bit            rx_idle = 1'b1;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("grid_maze_dfs_reachability_top regression: fail");
      $finish;
    end
  end

  function automatic int eff_rows();
    return (int'(row_count) < gmdr_pkg::MAX_ROWS) ? int'(row_count) : gmdr_pkg::MAX_ROWS;
  endfunction

  function automatic int eff_cols();
    return (int'(col_count) < gmdr_pkg::MAX_COLUMNS) ? int'(col_count) :
                                                        gmdr_pkg::MAX_COLUMNS;
  endfunction

  function automatic bit open_to_walk(int r, int c);
    logic [gmdr_pkg::KIND_W-1:0] k;
    if (r >= eff_rows() || c >= eff_cols()) return 1'b0;
    k = maze_cells[r*gmdr_pkg::MAX_COLUMNS + c];
    return (k == gmdr_pkg::KIND_OPEN) || (k == gmdr_pkg::KIND_EXIT);
  endfunction

  // returns 0 when the stack is already full
  function automatic bit push_move(int r, int c);
    if (!open_to_walk(r, c)) return 1'b1;
    if (trail_len >= gmdr_pkg::STACK_DEPTH) return 1'b0;
    trail[trail_len] = r*gmdr_pkg::MAX_COLUMNS + c;
    trail_len++;
    return 1'b1;
  endfunction

  function automatic walk_result_t walk_maze(int r0, int c0);
    walk_result_t res;
    int r;
    int c;
    int top;
    bit ok;
    bit done;
    r = r0;
    c = c0;
    trail_len = 0;
    done = 1'b0;
    res.status = gmdr_pkg::WALK_OUTSIDE;
    if (r0 < eff_rows() && c0 < eff_cols()) begin
      while (!done) begin
        if (maze_cells[r*gmdr_pkg::MAX_COLUMNS + c] == gmdr_pkg::KIND_EXIT) begin
          res.status = gmdr_pkg::WALK_FOUND;
          done = 1'b1;
        end else begin
          ok = 1'b1;
          if (r > 0) ok = push_move(r - 1, c);
          if (ok) ok = push_move(r, c + 1);
          if (ok) ok = push_move(r + 1, c);
          if (ok && c > 0) ok = push_move(r, c - 1);
          if (!ok) begin
            res.status = gmdr_pkg::WALK_OVERFLOW;
            done = 1'b1;
          end else begin
            maze_cells[r*gmdr_pkg::MAX_COLUMNS + c] = gmdr_pkg::KIND_VISITED;
            if (trail_len == 0) begin
              res.status = gmdr_pkg::WALK_NO_EXIT;
              done = 1'b1;
            end else begin
              trail_len--;
              top = trail[trail_len];
              r = top / gmdr_pkg::MAX_COLUMNS;
              c = top % gmdr_pkg::MAX_COLUMNS;
            end
          end
        end
      end
    end
    res.row = gmdr_pkg::IDX_W'(r);
    res.col = gmdr_pkg::IDX_W'(c);
    return res;
  endfunction

  function automatic void dir_cfg(logic [gmdr_pkg::CFG_IDX_W-1:0] idx, int val);
    directed_row_t d;
    d = '{default: '0};
    d.is_cfg = 1'b1;
    d.reg_idx = idx;
    d.reg_val = gmdr_pkg::CFG_W'(val);
    directed_rows.push_back(d);
  endfunction

  // a typed start always ends on its own start position
  function automatic void dir_item(logic op, int row, int col,
                                   logic [gmdr_pkg::KIND_W-1:0] kind, bit typed,
                                   logic [gmdr_pkg::STATUS_W-1:0] status);
    directed_row_t d;
    d = '{default: '0};
    d.item.op = op;
    d.item.row = gmdr_pkg::IDX_W'(row);
    d.item.col = gmdr_pkg::IDX_W'(col);
    d.item.kind = kind;
    d.typed = typed;
    d.want.status = status;
    d.want.row = gmdr_pkg::IDX_W'(row);
    d.want.col = gmdr_pkg::IDX_W'(col);
    directed_rows.push_back(d);
  endfunction

  function automatic logic [gmdr_pkg::KIND_W-1:0] draw_kind(int open_pct, int exit_pct);
    int p;
    p = int'($urandom_range(0, 99));
    if (p < open_pct) return gmdr_pkg::KIND_OPEN;
    if (p < open_pct + exit_pct) return gmdr_pkg::KIND_EXIT;
    if (p < open_pct + exit_pct + 4) return gmdr_pkg::KIND_VISITED;
    return gmdr_pkg::KIND_WALL;
  endfunction

  function automatic logic [gmdr_pkg::CFG_W-1:0] pick_count();
    int p;
    p = int'($urandom_range(0, 99));
    if (p < 4) return '0;
    if (p < 80) return gmdr_pkg::CFG_W'($urandom_range(1, 8));
    if (p < 92) return gmdr_pkg::CFG_W'($urandom_range(9, 24));
    return gmdr_pkg::CFG_W'($urandom_range(64, 127));
  endfunction

  task automatic send_item(input maze_item_t it, input bit typed, input walk_result_t want);
    int gap;
    walk_result_t got;
    gap = tx_idle ? int'($urandom_range(0, 12)) : 0;
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid        <= 1'b1;
    in_if.op           <= it.op;
    in_if.row_index    <= it.row;
    in_if.column_index <= it.col;
    in_if.cell_kind    <= it.kind;
    do @(posedge clk); while (!in_if.ready);
    if (it.op == gmdr_pkg::OP_WRITE) begin
      maze_cells[int'(it.row)*gmdr_pkg::MAX_COLUMNS + int'(it.col)] = it.kind;
    end else begin
      got = walk_maze(int'(it.row), int'(it.col));
      expected_walks.push_back(typed ? want : got);
    end
    items_sent++;
  endtask

  // stop offering items until every walk result has come back
  task automatic settle(input int extra);
    in_if.valid <= 1'b0;
    do @(posedge clk); while (expected_walks.size() != 0);
    repeat (extra) @(posedge clk);
  endtask

  task automatic write_reg(input logic [gmdr_pkg::CFG_IDX_W-1:0] idx,
                           input logic [gmdr_pkg::CFG_W-1:0] val);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    if (idx == gmdr_pkg::REG_ROW_COUNT) row_count = val;
    else if (idx == gmdr_pkg::REG_COLUMN_COUNT) col_count = val;
    @(posedge clk);
  endtask

  task automatic maze_phase(input bit full_grid);
    logic [gmdr_pkg::CFG_W-1:0] rows_val;
    logic [gmdr_pkg::CFG_W-1:0] cols_val;
    int rounds;
    int starts;
    int noise;
    int open_pct;
    int exit_pct;
    maze_item_t it;
    if (full_grid) begin
      rows_val = gmdr_pkg::CFG_W'(127);
      cols_val = gmdr_pkg::CFG_W'(CLOSING_COLS);
      open_pct = 85;
      exit_pct = 0;
      rounds = 1;
    end else begin
      rows_val = pick_count();
      cols_val = pick_count();
      if (rows_val > gmdr_pkg::CFG_W'(8)) begin
        cols_val = gmdr_pkg::CFG_W'($urandom_range(1, 4));
      end else if (cols_val > gmdr_pkg::CFG_W'(8)) begin
        rows_val = gmdr_pkg::CFG_W'($urandom_range(1, 4));
      end
      open_pct = 58;
      exit_pct = 7;
      rounds = int'($urandom_range(2, 5));
      if (rows_val > gmdr_pkg::CFG_W'(8) || cols_val > gmdr_pkg::CFG_W'(8)) rounds = 1;
    end
    settle(SETTLE_CYCLES);
    write_reg(gmdr_pkg::REG_ROW_COUNT, rows_val);
    write_reg(gmdr_pkg::REG_COLUMN_COUNT, cols_val);
    tx_idle = full_grid ? 1'b0 : ($urandom_range(0, 3) != 0);
    repeat (rounds) begin
      // reload the whole maze area so no walk reads a cell never written
      for (int r = 0; r < eff_rows(); r++) begin
        for (int c = 0; c < eff_cols(); c++) begin
          it.op = gmdr_pkg::OP_WRITE;
          it.row = gmdr_pkg::IDX_W'(r);
          it.col = gmdr_pkg::IDX_W'(c);
          it.kind = draw_kind(open_pct, exit_pct);
          send_item(it, 1'b0, '0);
        end
      end
      starts = int'($urandom_range(1, 3));
      repeat (starts) begin
        noise = int'($urandom_range(0, 2));
        repeat (noise) begin
          it.op = gmdr_pkg::OP_WRITE;
          it.row = gmdr_pkg::IDX_W'($urandom_range(0, 63));
          it.col = gmdr_pkg::IDX_W'($urandom_range(0, 63));
          it.kind = gmdr_pkg::KIND_W'($urandom_range(0, 3));
          send_item(it, 1'b0, '0);
        end
        it.op = gmdr_pkg::OP_START;
        it.kind = gmdr_pkg::KIND_W'($urandom_range(0, 3));
        if ($urandom_range(0, 4) != 0 && eff_rows() > 0 && eff_cols() > 0) begin
          it.row = gmdr_pkg::IDX_W'($urandom_range(0, eff_rows() - 1));
          it.col = gmdr_pkg::IDX_W'($urandom_range(0, eff_cols() - 1));
        end else begin
          it.row = gmdr_pkg::IDX_W'($urandom_range(0, 63));
          it.col = gmdr_pkg::IDX_W'($urandom_range(0, 63));
        end
        send_item(it, 1'b0, '0);
      end
      if ($urandom_range(0, 3) == 0) settle(0);
    end
  endtask

  initial begin : result_sink
    int wait_cycles;
    int seen;
    walk_result_t want;
    seen = 0;
    wait (rst_n === 1'b1);
    forever begin
      if (seen == 40 || seen == 90) wait_cycles = LONG_HOLD;
      else wait_cycles = rx_idle ? int'($urandom_range(0, 12)) : 0;
      if (wait_cycles > 0) begin
        out_if.ready <= 1'b0;
        repeat (wait_cycles) @(posedge clk);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk); while (!out_if.valid);
      seen++;
      if (seen % 64 == 0) rx_idle = ($urandom_range(0, 2) != 0);
      if (expected_walks.size() == 0) begin
        $error("walk result with nothing expected: status %0d row %0d column %0d",
               out_if.walk_status, out_if.final_row, out_if.final_column);
        errors++;
      end else begin
        want = expected_walks.pop_front();
        if (out_if.walk_status !== want.status) begin
          $error("walk_status: expected %0d, got %0d", want.status, out_if.walk_status);
          errors++;
        end
        if (out_if.final_row !== want.row) begin
          $error("final_row: expected %0d, got %0d", want.row, out_if.final_row);
          errors++;
        end
        if (out_if.final_column !== want.col) begin
          $error("final_column: expected %0d, got %0d", want.col, out_if.final_column);
          errors++;
        end
      end
    end
  end

  initial begin : stimulus
    rst_n              <= 1'b0;
    in_if.valid        <= 1'b0;
    in_if.op           <= gmdr_pkg::OP_WRITE;
    in_if.row_index    <= '0;
    in_if.column_index <= '0;
    in_if.cell_kind    <= gmdr_pkg::KIND_WALL;
    out_if.ready       <= 1'b0;
    cfg_if.valid       <= 1'b0;
    cfg_if.index       <= gmdr_pkg::REG_ROW_COUNT;
    cfg_if.data        <= '0;
    foreach (maze_cells[i]) maze_cells[i] = gmdr_pkg::KIND_WALL;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // single cell maze
    dir_cfg(gmdr_pkg::REG_ROW_COUNT, 1);
    dir_cfg(gmdr_pkg::REG_COLUMN_COUNT, 1);
    dir_item(gmdr_pkg::OP_WRITE, 0, 0, gmdr_pkg::KIND_EXIT, 1'b0, gmdr_pkg::WALK_NO_EXIT);
    dir_item(gmdr_pkg::OP_START, 0, 0, gmdr_pkg::KIND_WALL, 1'b1, gmdr_pkg::WALK_FOUND);
    dir_item(gmdr_pkg::OP_WRITE, 0, 0, gmdr_pkg::KIND_OPEN, 1'b0, gmdr_pkg::WALK_NO_EXIT);
    dir_item(gmdr_pkg::OP_START, 0, 0, gmdr_pkg::KIND_OPEN, 1'b1, gmdr_pkg::WALK_NO_EXIT);
    dir_item(gmdr_pkg::OP_START, 0, 1, gmdr_pkg::KIND_EXIT, 1'b1, gmdr_pkg::WALK_OUTSIDE);
    dir_item(gmdr_pkg::OP_START, 63, 63, gmdr_pkg::KIND_VISITED, 1'b1,
             gmdr_pkg::WALK_OUTSIDE);
    dir_item(gmdr_pkg::OP_WRITE, 0, 0, gmdr_pkg::KIND_VISITED, 1'b0,
             gmdr_pkg::WALK_NO_EXIT);
    dir_item(gmdr_pkg::OP_START, 0, 0, gmdr_pkg::KIND_WALL, 1'b1, gmdr_pkg::WALK_NO_EXIT);
    dir_item(gmdr_pkg::OP_WRITE, 0, 0, gmdr_pkg::KIND_WALL, 1'b0, gmdr_pkg::WALK_NO_EXIT);
    dir_item(gmdr_pkg::OP_START, 0, 0, gmdr_pkg::KIND_WALL, 1'b1, gmdr_pkg::WALK_NO_EXIT);
    dir_item(gmdr_pkg::OP_WRITE, 63, 63, gmdr_pkg::KIND_EXIT, 1'b0, gmdr_pkg::WALK_NO_EXIT);
    // empty grid settings
    dir_cfg(gmdr_pkg::REG_ROW_COUNT, 0);
    dir_item(gmdr_pkg::OP_START, 0, 0, gmdr_pkg::KIND_WALL, 1'b1, gmdr_pkg::WALK_OUTSIDE);
    dir_cfg(gmdr_pkg::REG_ROW_COUNT, 127);
    dir_cfg(gmdr_pkg::REG_COLUMN_COUNT, 0);
    dir_item(gmdr_pkg::OP_START, 63, 0, gmdr_pkg::KIND_WALL, 1'b1, gmdr_pkg::WALK_OUTSIDE);
    // 2x2 maze with one exit
    dir_cfg(gmdr_pkg::REG_ROW_COUNT, 2);
    dir_cfg(gmdr_pkg::REG_COLUMN_COUNT, 2);
    dir_item(gmdr_pkg::OP_WRITE, 0, 0, gmdr_pkg::KIND_OPEN, 1'b0, gmdr_pkg::WALK_NO_EXIT);
    dir_item(gmdr_pkg::OP_WRITE, 0, 1, gmdr_pkg::KIND_OPEN, 1'b0, gmdr_pkg::WALK_NO_EXIT);
    dir_item(gmdr_pkg::OP_WRITE, 1, 0, gmdr_pkg::KIND_WALL, 1'b0, gmdr_pkg::WALK_NO_EXIT);
    dir_item(gmdr_pkg::OP_WRITE, 1, 1, gmdr_pkg::KIND_EXIT, 1'b0, gmdr_pkg::WALK_NO_EXIT);
    dir_item(gmdr_pkg::OP_START, 0, 0, gmdr_pkg::KIND_WALL, 1'b0, gmdr_pkg::WALK_NO_EXIT);
    dir_item(gmdr_pkg::OP_START, 1, 0, gmdr_pkg::KIND_WALL, 1'b0, gmdr_pkg::WALK_NO_EXIT);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].is_cfg) begin
        settle(SETTLE_CYCLES);
        write_reg(directed_rows[i].reg_idx, directed_rows[i].reg_val);
      end else begin
        send_item(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].want);
      end
    end

    items_sent = 0;
    while (items_sent < ITEM_TARGET - CLOSING_RESERVE) maze_phase(1'b0);
    maze_phase(1'b1);

    settle(SETTLE_CYCLES);
    if (errors == 0) $display("grid_maze_dfs_reachability_top regression: pass");
    else $display("grid_maze_dfs_reachability_top regression: fail");
    $finish;
  end

endmodule
